@@ hw/rtl/hk_pkg.sv @@
package hk_pkg;

    localparam int FRAME_LEN  = 30;
    localparam int NUM_WORDS  = 11;
    localparam int WORD_IDX_W = 4;
    localparam int HDR_LEN    = 7;

    localparam logic [7:0] SOF          = 8'h7E;
    localparam logic [7:0] VERSION      = 8'h01;
    localparam logic [7:0] KIND_PSAVE   = 8'h12;
    localparam logic [7:0] KIND_MISSION = 8'h11;
    localparam logic [7:0] KIND_NORMAL  = 8'h10;
    localparam logic [7:0] PAYLOAD_LEN  = 8'd23;
    localparam logic [7:0] MODE_MISSION = 8'h01;
    localparam logic [7:0] MODE_IDLE    = 8'h00;

    localparam logic [1:0] CMD_ENTER = 2'd1;
    localparam logic [1:0] CMD_LEAVE = 2'd2;

    localparam logic [21:0] THRESH_RESET = 22'd235930;

    // Word slots in the frame body.
    localparam logic [WORD_IDX_W-1:0] IDX_BATT      = 4'd0;
    localparam logic [WORD_IDX_W-1:0] IDX_TEMP      = 4'd1;
    localparam logic [WORD_IDX_W-1:0] IDX_ACCEL_LO  = 4'd2;
    localparam logic [WORD_IDX_W-1:0] IDX_RATE_LO   = 4'd5;
    localparam logic [WORD_IDX_W-1:0] IDX_FIELD_LO  = 4'd8;
    localparam logic [WORD_IDX_W-1:0] IDX_LAST      = 4'd10;

    // Scale factors, unsigned with 16 fraction bits.
    localparam int K_W = 26;
    localparam logic [K_W-1:0] K_BATT  = 26'd56844219;
    localparam logic [K_W-1:0] K_TEMP  = 26'd655360;
    localparam logic [K_W-1:0] K_ACCEL = 26'd3423922;
    localparam logic [K_W-1:0] K_RATE  = 26'd1073742;
    localparam logic [K_W-1:0] K_FIELD = 26'd65536;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_word;

    typedef struct packed {
        t_byte                   kind;
        t_byte                   mode;
        logic [15:0]             seq;
        t_word [NUM_WORDS-1:0]   words;
        t_byte                   sum;
    } t_frame;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_cell_data;

    function automatic logic [K_W-1:0] scale_const(input logic [WORD_IDX_W-1:0] idx);
        logic [K_W-1:0] k;
        if (idx == IDX_BATT) begin
            k = K_BATT;
        end else if (idx == IDX_TEMP) begin
            k = K_TEMP;
        end else if (idx < IDX_RATE_LO) begin
            k = K_ACCEL;
        end else if (idx < IDX_FIELD_LO) begin
            k = K_RATE;
        end else begin
            k = K_FIELD;
        end
        return k;
    endfunction

endpackage

@@ hw/rtl/hk_cell.sv @@
module hk_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_shift,
    input  hk_pkg::t_cell_data i_load_data,
    input  hk_pkg::t_cell_data i_next_data,
    input  logic               i_next_valid,
    output hk_pkg::t_cell_data o_data,
    output logic               o_valid
);

    hk_pkg::t_cell_data r_data;
    logic               r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_shift) begin
            r_valid <= i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

@@ hw/rtl/hk_build.sv @@
module hk_build #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [21:0]         i_battery_volts,
    input  logic signed [31:0]  i_temperature,
    input  logic signed [31:0]  i_accel_x,
    input  logic signed [31:0]  i_accel_y,
    input  logic signed [31:0]  i_accel_z,
    input  logic signed [31:0]  i_rate_x,
    input  logic signed [31:0]  i_rate_y,
    input  logic signed [31:0]  i_rate_z,
    input  logic signed [31:0]  i_field_x,
    input  logic signed [31:0]  i_field_y,
    input  logic signed [31:0]  i_field_z,
    input  logic [1:0]          i_command,
    input  logic [21:0]         i_threshold,
    input  logic                i_load,
    output logic                o_frame_valid,
    output hk_pkg::t_frame      o_frame
);

    localparam int PW = 32 + hk_pkg::K_W;
    localparam int SH = FRACTION_BITS + 16;
    localparam int IW = hk_pkg::WORD_IDX_W;

    logic                       r_busy;
    logic                       r_issue;
    logic [IW-1:0]              r_idx;
    logic                       r_pvalid;
    logic [IW-1:0]              r_pidx;
    logic                       r_pneg;
    logic                       r_punsigned;
    logic [PW-1:0]              r_prod;
    logic                       r_done;
    logic                       r_mission;
    logic [15:0]                r_seq;
    hk_pkg::t_byte              r_kind;
    hk_pkg::t_byte              r_mode;
    hk_pkg::t_byte              r_sum;
    logic [31:0]                r_raw  [hk_pkg::NUM_WORDS];
    hk_pkg::t_word              r_word [hk_pkg::NUM_WORDS];

    logic                       w_accept;
    logic                       w_psave;
    logic                       n_mission;
    logic                       w_motion;
    logic [15:0]                n_seq;
    hk_pkg::t_byte              n_kind;
    hk_pkg::t_byte              n_mode;
    hk_pkg::t_byte              w_hdr_sum;
    logic [31:0]                w_raw;
    logic                       w_neg;
    logic [31:0]                w_mag;
    logic [PW-1:0]              w_q;
    hk_pkg::t_word              w_sat;

    assign o_in_ready = !r_busy;
    assign w_accept   = i_in_valid && !r_busy;

    // Tick decode: power save freezes the mission flag and ignores the command.
    always_comb begin
        w_psave   = i_battery_volts < i_threshold;
        n_mission = r_mission;
        if (!w_psave) begin
            if (i_command == hk_pkg::CMD_ENTER) begin
                n_mission = 1'b1;
            end else if (i_command == hk_pkg::CMD_LEAVE) begin
                n_mission = 1'b0;
            end
        end
        w_motion = !w_psave && n_mission;
        n_seq    = r_seq + 16'd1;
        if (w_psave) begin
            n_kind = hk_pkg::KIND_PSAVE;
        end else if (n_mission) begin
            n_kind = hk_pkg::KIND_MISSION;
        end else begin
            n_kind = hk_pkg::KIND_NORMAL;
        end
        n_mode    = w_motion ? hk_pkg::MODE_MISSION : hk_pkg::MODE_IDLE;
        w_hdr_sum = hk_pkg::VERSION + n_kind + n_seq[15:8] + n_seq[7:0]
                  + hk_pkg::PAYLOAD_LEN + n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mission <= 1'b0;
            r_seq     <= 16'd0;
        end else if (w_accept) begin
            r_mission <= n_mission;
            r_seq     <= n_seq;
        end
    end

    // Operands are stored already masked, so a cleared slot scales to zero.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind   <= n_kind;
            r_mode   <= n_mode;
            r_raw[0] <= {10'd0, i_battery_volts};
            r_raw[1] <= w_psave  ? 32'd0 : i_temperature;
            r_raw[2] <= w_motion ? i_accel_x : 32'd0;
            r_raw[3] <= w_motion ? i_accel_y : 32'd0;
            r_raw[4] <= w_motion ? i_accel_z : 32'd0;
            r_raw[5] <= w_motion ? i_rate_x  : 32'd0;
            r_raw[6] <= w_motion ? i_rate_y  : 32'd0;
            r_raw[7] <= w_motion ? i_rate_z  : 32'd0;
            r_raw[8] <= w_motion ? i_field_x : 32'd0;
            r_raw[9] <= w_motion ? i_field_y : 32'd0;
            r_raw[10] <= w_motion ? i_field_z : 32'd0;
        end
    end

    // Multiply stage: one word per cycle through a shared multiplier.
    always_comb begin
        w_raw = r_raw[r_idx];
        w_neg = (r_idx != hk_pkg::IDX_BATT) && w_raw[31];
        w_mag = w_neg ? (~w_raw + 32'd1) : w_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_issue  <= 1'b0;
            r_idx    <= '0;
            r_pvalid <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_pvalid <= r_issue;
            if (w_accept) begin
                r_busy  <= 1'b1;
                r_issue <= 1'b1;
                r_idx   <= '0;
            end else if (r_issue) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == hk_pkg::IDX_LAST) begin
                    r_issue <= 1'b0;
                end
            end
            if (r_pvalid && r_pidx == hk_pkg::IDX_LAST) begin
                r_done <= 1'b1;
            end else if (i_load) begin
                r_done <= 1'b0;
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx      <= r_idx;
        r_pneg      <= w_neg;
        r_punsigned <= r_idx == hk_pkg::IDX_BATT;
        r_prod      <= PW'(w_mag) * PW'(hk_pkg::scale_const(r_idx));
    end

    // Truncate, then saturate to 16 bits.
    always_comb begin
        w_q = r_prod >> SH;
        if (r_punsigned) begin
            w_sat = (w_q > PW'(65535)) ? 16'hFFFF : w_q[15:0];
        end else if (r_pneg) begin
            w_sat = (w_q >= PW'(32768)) ? 16'h8000 : (16'd0 - w_q[15:0]);
        end else begin
            w_sat = (w_q > PW'(32767)) ? 16'h7FFF : w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sum <= w_hdr_sum;
        end else if (r_pvalid) begin
            r_sum <= r_sum + w_sat[15:8] + w_sat[7:0];
        end
        if (r_pvalid) begin
            r_word[r_pidx] <= w_sat;
        end
    end

    assign o_frame_valid = r_done;

    always_comb begin
        o_frame.kind = r_kind;
        o_frame.mode = r_mode;
        o_frame.seq  = r_seq;
        o_frame.sum  = r_sum;
        for (int i = 0; i < hk_pkg::NUM_WORDS; i++) begin
            o_frame.words[i] = r_word[i];
        end
    end

endmodule

@@ hw/rtl/housekeeping_telemetry_framer_core.sv @@
// Every accepted telemetry tick produces one 30-byte frame on the output, one byte per
// accepted output request, with o_last_of_frame marking the checksum byte. A tick is scaled
// by one shared multiplier, one word per cycle, and the finished frame is loaded at once into
// a row of 30 byte cells that shifts toward the output. The next tick is taken as soon as the
// previous frame has moved into the cell row, so building overlaps sending and the sustained
// tick rate is set by the cell row, which emits one byte a cycle while the receiver accepts.
// The threshold register may be rewritten only while no frame is in flight.
module housekeeping_telemetry_framer_core #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [21:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [21:0]         i_battery_volts,
    input  logic signed [31:0]  i_temperature,
    input  logic signed [31:0]  i_accel_x,
    input  logic signed [31:0]  i_accel_y,
    input  logic signed [31:0]  i_accel_z,
    input  logic signed [31:0]  i_rate_x,
    input  logic signed [31:0]  i_rate_y,
    input  logic signed [31:0]  i_rate_z,
    input  logic signed [31:0]  i_field_x,
    input  logic signed [31:0]  i_field_y,
    input  logic signed [31:0]  i_field_z,
    input  logic [1:0]          i_command,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_tx_byte,
    output logic                o_last_of_frame
);

    localparam int N = hk_pkg::FRAME_LEN;

    logic [21:0]        r_threshold;
    logic               w_frame_valid;
    hk_pkg::t_frame     w_frame;
    logic               w_load;
    logic               w_shift;
    hk_pkg::t_cell_data w_load_data [N];
    hk_pkg::t_cell_data w_cell_data [N];
    logic [N-1:0]       w_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= hk_pkg::THRESH_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    hk_build #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_build (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_battery_volts(i_battery_volts),
        .i_temperature  (i_temperature),
        .i_accel_x      (i_accel_x),
        .i_accel_y      (i_accel_y),
        .i_accel_z      (i_accel_z),
        .i_rate_x       (i_rate_x),
        .i_rate_y       (i_rate_y),
        .i_rate_z       (i_rate_z),
        .i_field_x      (i_field_x),
        .i_field_y      (i_field_y),
        .i_field_z      (i_field_z),
        .i_command      (i_command),
        .i_threshold    (r_threshold),
        .i_load         (w_load),
        .o_frame_valid  (w_frame_valid),
        .o_frame        (w_frame)
    );

    // A new frame enters when the row is empty or its last byte is leaving.
    assign w_shift = o_out_valid && i_out_ready;
    assign w_load  = w_frame_valid
                  && (!w_valid[0] || (w_cell_data[0].last && i_out_ready));

    always_comb begin
        w_load_data[0] = '{data: hk_pkg::SOF,          last: 1'b0};
        w_load_data[1] = '{data: hk_pkg::VERSION,      last: 1'b0};
        w_load_data[2] = '{data: w_frame.kind,         last: 1'b0};
        w_load_data[3] = '{data: w_frame.seq[15:8],    last: 1'b0};
        w_load_data[4] = '{data: w_frame.seq[7:0],     last: 1'b0};
        w_load_data[5] = '{data: hk_pkg::PAYLOAD_LEN,  last: 1'b0};
        w_load_data[6] = '{data: w_frame.mode,         last: 1'b0};
        for (int i = 0; i < hk_pkg::NUM_WORDS; i++) begin
            w_load_data[hk_pkg::HDR_LEN + 2*i]     = '{data: w_frame.words[i][15:8], last: 1'b0};
            w_load_data[hk_pkg::HDR_LEN + 2*i + 1] = '{data: w_frame.words[i][7:0],  last: 1'b0};
        end
        w_load_data[N-1] = '{data: w_frame.sum, last: 1'b1};
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        hk_pkg::t_cell_data w_next_data;
        logic               w_next_valid;
        if (g == N - 1) begin : g_tail
            assign w_next_data  = '0;
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next_data  = w_cell_data[g+1];
            assign w_next_valid = w_valid[g+1];
        end
        hk_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (w_load),
            .i_shift     (w_shift),
            .i_load_data (w_load_data[g]),
            .i_next_data (w_next_data),
            .i_next_valid(w_next_valid),
            .o_data      (w_cell_data[g]),
            .o_valid     (w_valid[g])
        );
    end

    assign o_out_valid     = w_valid[0];
    assign o_tx_byte       = w_cell_data[0].data;
    assign o_last_of_frame = w_cell_data[0].last;

    a_load_starts_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && o_tx_byte == hk_pkg::SOF && !o_last_of_frame))
        else $error("frame load did not present a start byte");

    a_last_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_of_frame) |-> !w_valid[1])
        else $error("cells still valid behind the checksum byte");

    a_shift_drops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_shift && !w_load) |=> ($countones(w_valid) == $past($countones(w_valid)) - 1))
        else $error("cell row lost or duplicated a byte");

    a_load_fills_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (&w_valid))
        else $error("frame load left an empty cell");

endmodule

@@ dv/tb_housekeeping_telemetry_framer_core.sv @@
module tb_housekeeping_telemetry_framer_core;

    localparam int FRACTION_BITS = 16;
    localparam int FRAME_BYTES   = 30;
    localparam int WORD_COUNT    = 11;
    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_OFF      = 400;

    localparam logic [21:0] VOLTS_MAX        = 22'h3F_FFFF;
    localparam logic [21:0] THRESHOLD_RESET  = 22'd235930;

    // Scale factors, unsigned with 16 fraction bits.
    localparam logic [25:0] SCALE_BATT  = 26'd56844219;
    localparam logic [25:0] SCALE_TEMP  = 26'd655360;
    localparam logic [25:0] SCALE_ACCEL = 26'd3423922;
    localparam logic [25:0] SCALE_RATE  = 26'd1073742;
    localparam logic [25:0] SCALE_FIELD = 26'd65536;

    localparam logic [7:0] SYNC_BYTE        = 8'h7E;
    localparam logic [7:0] PROTO_VERSION    = 8'h01;
    localparam logic [7:0] BODY_LEN         = 8'd23;
    localparam logic [7:0] FRAME_POWER_SAVE = 8'h12;
    localparam logic [7:0] FRAME_MISSION    = 8'h11;
    localparam logic [7:0] FRAME_NORMAL     = 8'h10;
    localparam logic [7:0] MODE_ACTIVE      = 8'h01;
    localparam logic [7:0] MODE_OFF         = 8'h00;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_ENTER_MISSION,
        CMD_LEAVE_MISSION,
        CMD_RESERVED
    } t_mission_cmd;

    // motion[0..2] accel x/y/z, motion[3..5] rate x/y/z, motion[6..8] field x/y/z.
    typedef struct packed {
        logic [21:0]      volts;
        logic [31:0]      temp;
        logic [8:0][31:0] motion;
        t_mission_cmd     cmd;
    } t_tick;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_frame_byte;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [21:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [21:0] battery_volts;
    logic [31:0] temperature;
    logic [31:0] accel_x, accel_y, accel_z;
    logic [31:0] rate_x, rate_y, rate_z;
    logic [31:0] field_x, field_y, field_z;
    logic [1:0]  command;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  tx_byte;
    logic        last_of_frame;

    // Shadow of the block's state and threshold register.
    logic [21:0] model_threshold;
    logic        mission_on;
    logic [15:0] frame_seq;

    t_frame_byte frame_bytes_due[$];
    int          mismatches = 0;
    int          bytes_seen = 0;
    int          stall_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_target = 0;
    int          hold_count = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    housekeeping_telemetry_framer_core #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_top (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_data(cfg_data),
        .i_in_valid(in_valid),
        .o_in_ready(in_ready),
        .i_battery_volts(battery_volts),
        .i_temperature(temperature),
        .i_accel_x(accel_x),
        .i_accel_y(accel_y),
        .i_accel_z(accel_z),
        .i_rate_x(rate_x),
        .i_rate_y(rate_y),
        .i_rate_z(rate_z),
        .i_field_x(field_x),
        .i_field_y(field_y),
        .i_field_z(field_z),
        .i_command(command),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_tx_byte(tx_byte),
        .o_last_of_frame(last_of_frame)
    );

    function automatic logic [15:0] scale_to_word(input logic [31:0] raw,
                                                  input logic [25:0] k);
        logic [31:0] mag;
        logic [63:0] q;
        mag = raw[31] ? (~raw + 32'd1) : raw;
        q = ({32'd0, mag} * {38'd0, k}) >> (FRACTION_BITS + 16);
        if (raw[31]) begin
            if (q >= 64'd32768) begin
                return 16'h8000;
            end
            return ~q[15:0] + 16'd1;
        end
        if (q > 64'd32767) begin
            return 16'h7FFF;
        end
        return q[15:0];
    endfunction

    function automatic logic [15:0] scale_volts(input logic [21:0] volts);
        logic [63:0] q;
        q = ({42'd0, volts} * {38'd0, SCALE_BATT}) >> (FRACTION_BITS + 16);
        if (q > 64'd65535) begin
            return 16'hFFFF;
        end
        return q[15:0];
    endfunction

    // Works out the frame for one accepted tick and queues its bytes.
    function automatic void predict_frame(input t_tick t);
        logic [15:0] words [WORD_COUNT];
        logic [7:0]  octets [FRAME_BYTES];
        logic [7:0]  kind;
        logic [7:0]  mode;
        logic [7:0]  sum;
        for (int w = 0; w < WORD_COUNT; w++) begin
            words[w] = 16'd0;
        end
        words[0] = scale_volts(t.volts);
        if (t.volts < model_threshold) begin
            kind = FRAME_POWER_SAVE;
            mode = MODE_OFF;
        end else begin
            if (t.cmd == CMD_ENTER_MISSION) begin
                mission_on = 1'b1;
            end else if (t.cmd == CMD_LEAVE_MISSION) begin
                mission_on = 1'b0;
            end
            words[1] = scale_to_word(t.temp, SCALE_TEMP);
            if (mission_on) begin
                for (int a = 0; a < 3; a++) begin
                    words[2 + a] = scale_to_word(t.motion[a], SCALE_ACCEL);
                    words[5 + a] = scale_to_word(t.motion[3 + a], SCALE_RATE);
                    words[8 + a] = scale_to_word(t.motion[6 + a], SCALE_FIELD);
                end
                kind = FRAME_MISSION;
                mode = MODE_ACTIVE;
            end else begin
                kind = FRAME_NORMAL;
                mode = MODE_OFF;
            end
        end
        frame_seq = frame_seq + 16'd1;
        octets[0] = SYNC_BYTE;
        octets[1] = PROTO_VERSION;
        octets[2] = kind;
        octets[3] = frame_seq[15:8];
        octets[4] = frame_seq[7:0];
        octets[5] = BODY_LEN;
        octets[6] = mode;
        for (int w = 0; w < WORD_COUNT; w++) begin
            octets[7 + 2 * w] = words[w][15:8];
            octets[8 + 2 * w] = words[w][7:0];
        end
        sum = 8'd0;
        for (int i = 1; i < FRAME_BYTES - 1; i++) begin
            sum = sum + octets[i];
        end
        octets[FRAME_BYTES - 1] = sum;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            frame_bytes_due.push_back('{octets[i], i == FRAME_BYTES - 1});
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("mismatch at output byte %0d: %s got %h want %h",
                     bytes_seen, what, got, want);
        end
    endtask

    always @(posedge clk) begin : check_bytes
        t_frame_byte want;
        if (rst_n && out_valid && out_ready) begin
            if (frame_bytes_due.size() == 0) begin
                report_mismatch("byte with no frame due", tx_byte, 8'h00);
            end else begin
                want = frame_bytes_due.pop_front();
                if (tx_byte !== want.data) begin
                    report_mismatch("tx_byte", tx_byte, want.data);
                end
                if (last_of_frame !== want.last) begin
                    report_mismatch("last_of_frame", {7'd0, last_of_frame}, {7'd0, want.last});
                end
            end
            bytes_seen++;
        end
    end

    // The receiver counts its own long hold-off whenever the test raises the target.
    always @(posedge clk) begin
        if (hold_count < hold_target) begin
            out_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_tick(input t_tick t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        battery_volts <= t.volts;
        temperature   <= t.temp;
        accel_x       <= t.motion[0];
        accel_y       <= t.motion[1];
        accel_z       <= t.motion[2];
        rate_x        <= t.motion[3];
        rate_y        <= t.motion[4];
        rate_z        <= t.motion[5];
        field_x       <= t.motion[6];
        field_y       <= t.motion[7];
        field_z       <= t.motion[8];
        command       <= t.cmd;
        @(posedge clk);
        while (in_ready !== 1'b1) begin
            @(posedge clk);
        end
        predict_frame(t);
    endtask

    // Waits on the clock before it first checks the queue, so the next request is driven in a later step.
    task automatic wait_frames_out();
        in_valid <= 1'b0;
        do begin
            @(posedge clk);
        end while (frame_bytes_due.size() != 0);
    endtask

    task automatic write_threshold(input logic [21:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        model_threshold = value;
        @(posedge clk);
    endtask

    function automatic t_tick make_tick(input logic [21:0] volts, input logic [31:0] temp,
                                        input logic [31:0] fill, input t_mission_cmd cmd);
        t_tick t;
        t.volts = volts;
        t.temp  = temp;
        t.cmd   = cmd;
        for (int i = 0; i < 9; i++) begin
            t.motion[i] = fill;
        end
        return t;
    endfunction

    // Smallest magnitude whose scaled value no longer fits in 15 bits.
    function automatic logic [31:0] saturation_edge(input logic [25:0] k);
        logic [63:0] e;
        e = ((64'd32768 << (FRACTION_BITS + 16)) + {38'd0, k} - 64'd1) / {38'd0, k};
        return e[31:0];
    endfunction

    function automatic logic [31:0] random_q16();
        logic [31:0] v;
        logic [19:0] r;
        r = 20'($urandom);
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: begin
                v = $urandom >> $urandom_range(0, 31);
                if ($urandom_range(0, 1) == 1) begin
                    v = -v;
                end
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
            default: v = {{12{r[19]}}, r};
        endcase
        return v;
    endfunction

    // Mostly valid ticks above the threshold with a fair share of mission commands.
    function automatic t_tick random_tick();
        t_tick t;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            t.volts = 22'($urandom);
        end else if (pick < 25 && model_threshold != 22'd0) begin
            t.volts = 22'($urandom_range(0, model_threshold - 1));
        end else begin
            t.volts = 22'($urandom_range(model_threshold, VOLTS_MAX));
        end
        t.temp = random_q16();
        for (int i = 0; i < 9; i++) begin
            t.motion[i] = random_q16();
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            t.cmd = CMD_NONE;
        end else if (pick < 78) begin
            t.cmd = CMD_ENTER_MISSION;
        end else if (pick < 93) begin
            t.cmd = CMD_LEAVE_MISSION;
        end else begin
            t.cmd = CMD_RESERVED;
        end
        return t;
    endfunction

    // Assumes the threshold still holds its reset value.
    task automatic test_power_save_edge();
        send_tick(make_tick(THRESHOLD_RESET - 22'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            CMD_ENTER_MISSION));
        send_tick(make_tick(THRESHOLD_RESET, 32'h8000_0000, 32'h7FFF_FFFF, CMD_NONE));
        send_tick(make_tick(22'd0, 32'h0001_0000, 32'h8000_0000, CMD_LEAVE_MISSION));
    endtask

    task automatic test_mission_mode();
        t_tick t;
        t = make_tick(VOLTS_MAX, 32'hFFFF_FFFF, 32'd0, CMD_ENTER_MISSION);
        t.motion[0] = 32'h7FFF_FFFF;
        t.motion[1] = 32'h8000_0000;
        t.motion[3] = 32'hFFFF_FFFF;
        t.motion[4] = 32'h0012_3456;
        t.motion[5] = 32'hFFF0_1234;
        t.motion[6] = 32'h7FFF_0000;
        t.motion[7] = 32'h8000_0000;
        t.motion[8] = 32'h0001_0000;
        send_tick(t);
        t = random_tick();
        t.volts = VOLTS_MAX - 22'd5;
        t.cmd = CMD_RESERVED;
        send_tick(t);
        // A low battery must not let the leave command through.
        send_tick(make_tick(22'd1000, 32'h0005_0000, 32'h0100_0000, CMD_LEAVE_MISSION));
        send_tick(make_tick(22'd300000, 32'hFFFB_0000, 32'h0100_0000, CMD_NONE));
        send_tick(make_tick(22'd400000, 32'h0019_8000, 32'h0100_0000, CMD_LEAVE_MISSION));
        send_tick(make_tick(22'd500000, 32'h0000_8000, 32'h0100_0000, CMD_RESERVED));
    endtask

    task automatic test_saturation();
        logic [31:0] edge_t;
        logic [31:0] edge_a;
        logic [31:0] edge_r;
        t_tick t;
        edge_t = saturation_edge(SCALE_TEMP);
        edge_a = saturation_edge(SCALE_ACCEL);
        edge_r = saturation_edge(SCALE_RATE);
        t = make_tick(VOLTS_MAX, edge_t - 32'd1, 32'd0, CMD_ENTER_MISSION);
        t.motion[0] = edge_a - 32'd1;
        t.motion[1] = -(edge_a - 32'd1);
        t.motion[2] = -edge_a;
        t.motion[3] = edge_r - 32'd1;
        t.motion[4] = -(edge_r - 32'd1);
        t.motion[5] = -edge_r;
        t.motion[6] = -32'd65535;
        t.motion[7] = -32'd65536;
        t.motion[8] = 32'h7FFF_FFFF;
        send_tick(t);
        t = make_tick(VOLTS_MAX, -edge_t, 32'd0, CMD_NONE);
        t.motion[0] = edge_a;
        t.motion[1] = -edge_a;
        t.motion[3] = edge_r;
        t.motion[4] = -edge_r;
        t.motion[6] = 32'h8000_0000;
        t.motion[7] = 32'h7FFF_0000;
        t.motion[8] = 32'hFFFF_FFFF;
        send_tick(t);
        // Small negative values must truncate toward zero, not round down.
        send_tick(make_tick(22'd2000000, -edge_t + 32'd1, 32'hFFFF_FFFF, CMD_NONE));
    endtask

    task automatic test_threshold_extremes();
        wait_frames_out();
        write_threshold(22'd0);
        send_tick(make_tick(22'd0, 32'h0002_0000, 32'h0003_0000, CMD_NONE));
        wait_frames_out();
        write_threshold(VOLTS_MAX);
        send_tick(make_tick(VOLTS_MAX, 32'h0002_0000, 32'h0003_0000, CMD_NONE));
        send_tick(make_tick(VOLTS_MAX - 22'd1, 32'h0002_0000, 32'h0003_0000, CMD_LEAVE_MISSION));
        wait_frames_out();
        write_threshold(22'd1);
        send_tick(make_tick(22'd0, 32'h0002_0000, 32'h0003_0000, CMD_NONE));
        send_tick(make_tick(22'd1, 32'h0002_0000, 32'h0003_0000, CMD_NONE));
        wait_frames_out();
        write_threshold(THRESHOLD_RESET);
    endtask

    // The receiver stops for a long stretch while the sender keeps requesting,
    // so the block fills up and holds its input ready low.
    task automatic test_backpressure();
        wait_frames_out();
        send_idle_pct = 0;
        hold_target <= hold_target + HOLD_OFF;
        for (int i = 0; i < 8; i++) begin
            send_tick(random_tick());
        end
        wait_frames_out();
    endtask

    task automatic test_random_traffic(input int count, input int sender_idle,
                                       input int receiver_idle);
        wait_frames_out();
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        if ($urandom_range(0, 1) == 1) begin
            write_threshold(THRESHOLD_RESET);
        end else begin
            write_threshold(22'($urandom));
        end
        for (int i = 0; i < count; i++) begin
            // Halfway through, the sender pauses until every frame is out.
            if (i == count / 2) begin
                wait_frames_out();
            end
            send_tick(random_tick());
        end
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = 22'd0;
        in_valid      = 1'b0;
        battery_volts = 22'd0;
        temperature   = 32'd0;
        accel_x       = 32'd0;
        accel_y       = 32'd0;
        accel_z       = 32'd0;
        rate_x        = 32'd0;
        rate_y        = 32'd0;
        rate_z        = 32'd0;
        field_x       = 32'd0;
        field_y       = 32'd0;
        field_z       = 32'd0;
        command       = CMD_NONE;
        model_threshold = THRESHOLD_RESET;
        mission_on      = 1'b0;
        frame_seq       = 16'd0;
        send_idle_pct   = 37;
        recv_idle_pct   = 51;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_save_edge();
        test_mission_mode();
        test_saturation();
        test_threshold_extremes();
        test_backpressure();
        test_random_traffic(40, 37, 51);
        test_random_traffic(40, 51, 37);
        test_random_traffic(40, 0, 0);

        wait_frames_out();
        repeat (40) @(posedge clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
